// ===== rtl/core/fpba_pkg.sv =====
`default_nettype none

package fpba_pkg;

    localparam int NUM_BLOCKS = 16;
    localparam int SIZE_BITS  = 16;
    localparam int IDX_BITS   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_BITS   = $clog2(NUM_BLOCKS + 1);

    // configuration register indexes
    localparam logic CFG_FIT_MODE      = 1'b0;
    localparam logic CFG_BLOCKS_IN_USE = 1'b1;

    // placement policies, the unused code behaves as first fit
    localparam logic [1:0] MODE_FIRST = 2'd0;
    localparam logic [1:0] MODE_BEST  = 2'd1;
    localparam logic [1:0] MODE_WORST = 2'd2;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [3:0]  load_slot;
        logic [15:0] amount;
    } t_in;

    typedef struct packed {
        logic        granted;
        logic [3:0]  chosen_slot;
        logic [15:0] space_left;
    } t_out;

    typedef struct packed {
        logic                 rd_en;
        logic [IDX_BITS-1:0]  rd_addr;
        logic                 wr_en;
        logic [IDX_BITS-1:0]  wr_addr;
        logic [SIZE_BITS-1:0] wr_data;
    } t_mem_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/core/fpba_store.sv =====
`default_nettype none

module fpba_store (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire fpba_pkg::t_mem_req            i_req,
    output logic [fpba_pkg::SIZE_BITS-1:0]     o_rd_size
);
    import fpba_pkg::*;

    logic [SIZE_BITS-1:0]  r_mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] r_valid;
    logic [SIZE_BITS-1:0]  r_rd_data;
    logic                  r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    // entries never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_valid[i_req.rd_addr];
            end
        end
    end

    assign o_rd_size = r_rd_vld ? r_rd_data : '0;

endmodule

`default_nettype wire

// ===== rtl/core/fit_policy_block_allocator.sv =====
`default_nettype none

// Free-size table allocator with first, best or worst fit placement. Every
// transaction taken on start while busy is low gives one result, shown on o_out
// for a single cycle with o_done; the receiver cannot stall it. A load writes
// the table and returns its result the next cycle without raising busy. An
// allocate walks the table through the single read port of the free-size
// memory, one entry per cycle, so busy stays high while the searched
// entries are read and the pick is written back, the searched count being
// blocks_in_use capped at the table size (none when nothing is searched,
// fewer under first fit when an early block fits), and the result follows
// in the cycle busy drops. The table reads as zero after reset.
module fit_policy_block_allocator (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire fpba_pkg::t_in  i_in,
    output logic                o_done,
    output fpba_pkg::t_out      o_out,
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire logic           i_cfg_index,
    input  wire logic [4:0]     i_cfg_data
);
    import fpba_pkg::*;

    t_state r_state, n_state;

    logic [1:0]           r_fit_mode;
    logic [4:0]           r_blocks;
    logic [1:0]           r_mode, n_mode;
    logic [SIZE_BITS-1:0] r_amt, n_amt;
    logic [CNT_BITS-1:0]  r_count, n_count;
    logic [CNT_BITS-1:0]  r_addr, n_addr;
    logic                 r_pend, n_pend;
    logic [IDX_BITS-1:0]  r_pend_idx, n_pend_idx;
    logic                 r_found, n_found;
    logic [IDX_BITS-1:0]  r_pick, n_pick;
    logic [SIZE_BITS-1:0] r_best, n_best;
    logic                 r_done, n_done;
    t_out                 r_out, n_out;

    t_mem_req             mem_req;
    logic [SIZE_BITS-1:0] rd_size;

    logic                 accept;
    logic                 issue;
    logic                 fits;
    logic                 take;
    logic                 first_hit;
    logic                 last;
    logic                 load_ok;
    logic [SIZE_BITS-1:0] in_amt;
    logic [SIZE_BITS-1:0] left;

    fpba_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_size (rd_size)
    );

    assign accept  = start && !busy;
    assign in_amt  = SIZE_BITS'(i_in.amount);
    assign load_ok = 32'(i_in.load_slot) < NUM_BLOCKS;
    assign issue   = r_addr < r_count;
    assign fits    = rd_size >= r_amt;
    assign last    = (CNT_BITS'(r_pend_idx) + CNT_BITS'(1)) == r_count;
    assign left    = r_best - r_amt;

    always_comb begin
        take = 1'b0;
        if (fits) begin
            case (r_mode)
                MODE_BEST:  take = !r_found || (rd_size < r_best);
                MODE_WORST: take = !r_found || (rd_size > r_best);
                default:    take = !r_found;
            endcase
        end
    end

    assign first_hit = fits && !(r_mode == MODE_BEST || r_mode == MODE_WORST);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_in.cmd == CMD_ALLOC) begin
                    n_state = (n_count == '0) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_pend && (last || first_hit)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath, memory requests and results
    always_comb begin
        n_mode     = r_mode;
        n_amt      = r_amt;
        n_count    = r_count;
        n_addr     = r_addr;
        n_pend     = 1'b0;
        n_pend_idx = r_pend_idx;
        n_found    = r_found;
        n_pick     = r_pick;
        n_best     = r_best;
        n_done     = 1'b0;
        n_out      = r_out;
        mem_req    = '0;

        if (32'(r_blocks) > NUM_BLOCKS) begin
            n_count = CNT_BITS'(NUM_BLOCKS);
        end else begin
            n_count = CNT_BITS'(r_blocks);
        end

        case (r_state)
            ST_IDLE: begin
                n_count = r_count;
                if (32'(r_blocks) > NUM_BLOCKS) begin
                    n_count = CNT_BITS'(NUM_BLOCKS);
                end else begin
                    n_count = CNT_BITS'(r_blocks);
                end
                if (accept) begin
                    if (i_in.cmd == CMD_LOAD) begin
                        mem_req.wr_en   = load_ok;
                        mem_req.wr_addr = IDX_BITS'(i_in.load_slot);
                        mem_req.wr_data = in_amt;
                        n_done          = 1'b1;
                        n_out.granted     = 1'b0;
                        n_out.chosen_slot = i_in.load_slot;
                        n_out.space_left  = load_ok ? 16'(in_amt) : 16'd0;
                    end else begin
                        n_mode  = r_fit_mode;
                        n_amt   = in_amt;
                        n_addr  = '0;
                        n_found = 1'b0;
                        n_pick  = '0;
                        n_best  = '0;
                    end
                end else begin
                    n_count = r_count;
                end
            end
            ST_SCAN: begin
                mem_req.rd_en   = issue;
                mem_req.rd_addr = r_addr[IDX_BITS-1:0];
                if (issue) begin
                    n_addr = r_addr + CNT_BITS'(1);
                end
                n_pend     = issue;
                n_pend_idx = r_addr[IDX_BITS-1:0];
                if (r_pend && take) begin
                    n_found = 1'b1;
                    n_pick  = r_pend_idx;
                    n_best  = rd_size;
                end
                if (r_pend && (last || first_hit)) begin
                    n_pend = 1'b0;
                end
                n_count = r_count;
            end
            ST_DONE: begin
                mem_req.wr_en   = r_found;
                mem_req.wr_addr = r_pick;
                mem_req.wr_data = left;
                n_done          = 1'b1;
                n_out.granted     = r_found;
                n_out.chosen_slot = r_found ? 4'(r_pick) : 4'd0;
                n_out.space_left  = r_found ? 16'(left) : 16'd0;
                n_count = r_count;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_fit_mode <= MODE_FIRST;
            r_blocks   <= 5'd16;
            r_pend     <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_done  <= n_done;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_FIT_MODE:      r_fit_mode <= i_cfg_data[1:0];
                    CFG_BLOCKS_IN_USE: r_blocks   <= i_cfg_data;
                    default:           r_blocks   <= r_blocks;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_amt      <= n_amt;
        r_count    <= n_count;
        r_addr     <= n_addr;
        r_pend_idx <= n_pend_idx;
        r_found    <= n_found;
        r_pick     <= n_pick;
        r_best     <= n_best;
        r_out      <= n_out;
    end

    assign busy        = (r_state != ST_IDLE);
    assign o_done      = r_done;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe raised while an allocate is in progress");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (o_done || busy))
        else $error("accepted transaction neither answered nor in progress");

    a_done_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |=> (o_done && !busy))
        else $error("allocate finished without a result");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_out.granted && $past(r_state) == ST_DONE)
            |-> (o_out.chosen_slot == 4'd0 && o_out.space_left == 16'd0))
        else $error("refused allocate reports a block");

    a_scan_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_addr <= r_count))
        else $error("scan address ran past the searched blocks");

endmodule

`default_nettype wire

// ===== dv/fit_policy_block_allocator_tb.sv =====
`default_nettype none

module fit_policy_block_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fpba_pkg::*;

    // the fourth mode code has no name in the package and acts as first fit
    localparam logic [1:0] MODE_SPARE = 2'd3;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       start       = 1'b0;
    logic       busy;
    t_in        i_in        = '0;
    logic       o_done;
    t_out       o_out;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic       i_cfg_index = CFG_FIT_MODE;
    logic [4:0] i_cfg_data  = '0;

    fit_policy_block_allocator uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_in       (i_in),
        .o_done     (o_done),
        .o_out      (o_out),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mirror of the free-size table and the two registers
    logic [15:0] free_tbl [NUM_BLOCKS];
    logic [1:0]  mode_q   = MODE_FIRST;
    logic [4:0]  blocks_q = 5'd16;

    t_out pending_results [$];

    int unsigned errors      = 0;
    int unsigned n_loads     = 0;
    int unsigned n_allocs    = 0;
    int unsigned n_granted   = 0;
    int unsigned n_checked   = 0;
    int unsigned burst_left  = 0;
    bit          idle_on     = 1'b1;

    function automatic t_out apply_to_table(t_in it);
        t_out r;
        int   n;
        bit   found;
        int   pick;
        r = '0;
        if (it.cmd == CMD_LOAD) begin
            free_tbl[it.load_slot] = it.amount;
            r.chosen_slot = it.load_slot;
            r.space_left  = it.amount;
            return r;
        end
        n     = (blocks_q > NUM_BLOCKS) ? NUM_BLOCKS : int'(blocks_q);
        found = 1'b0;
        pick  = 0;
        for (int j = 0; j < n; j++) begin
            if (free_tbl[j] < it.amount)
                continue;
            if (!found) begin
                found = 1'b1;
                pick  = j;
                if (mode_q == MODE_FIRST || mode_q == MODE_SPARE)
                    break;
            end else if (mode_q == MODE_BEST && free_tbl[j] < free_tbl[pick]) begin
                pick = j;
            end else if (mode_q == MODE_WORST && free_tbl[j] > free_tbl[pick]) begin
                pick = j;
            end
        end
        if (found) begin
            free_tbl[pick] = free_tbl[pick] - it.amount;
            r.granted      = 1'b1;
            r.chosen_slot  = pick[3:0];
            r.space_left   = free_tbl[pick];
        end
        return r;
    endfunction

    function automatic t_in mk(logic cmd, logic [3:0] slot, logic [15:0] amt);
        t_in it;
        it.cmd       = cmd;
        it.load_slot = slot;
        it.amount    = amt;
        return it;
    endfunction

    // bursts of back-to-back transactions separated by random gaps, none while idle_on is clear
    function automatic int unsigned pick_gap();
        if (!idle_on)
            return 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            return ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 5);
        end
        burst_left--;
        return 0;
    endfunction

    task automatic send_item(t_in it);
        int unsigned gap;
        t_out        r;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_in  <= it;
        do @(posedge i_clk); while (busy);
        r = apply_to_table(it);
        pending_results.push_back(r);
        if (it.cmd == CMD_LOAD) begin
            n_loads++;
        end else begin
            n_allocs++;
            if (r.granted)
                n_granted++;
        end
    endtask

    // drop start and wait until every expected result has been seen
    task automatic settle();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [4:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_FIT_MODE)
            mode_q = val[1:0];
        else
            blocks_q = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin : check_results
        t_out want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result granted=%0b slot=%0d left=%0d", $time,
                         o_out.granted, o_out.chosen_slot, o_out.space_left);
            end else begin
                want = pending_results.pop_front();
                n_checked++;
                if (o_out.granted !== want.granted) begin
                    errors++;
                    $display("%0t: granted expected %0b actual %0b", $time,
                             want.granted, o_out.granted);
                end
                if (o_out.chosen_slot !== want.chosen_slot) begin
                    errors++;
                    $display("%0t: chosen_slot expected %0d actual %0d", $time,
                             want.chosen_slot, o_out.chosen_slot);
                end
                if (o_out.space_left !== want.space_left) begin
                    errors++;
                    $display("%0t: space_left expected %0d actual %0d", $time,
                             want.space_left, o_out.space_left);
                end
            end
        end
    end

    // table comes out of reset empty: a zero request fits, anything else is refused
    task automatic test_cleared_table();
        send_item(mk(CMD_ALLOC, 4'hF, 16'd0));
        send_item(mk(CMD_ALLOC, 4'h0, 16'd1));
        settle();
        write_reg(CFG_FIT_MODE, {3'b000, MODE_FIRST});
        write_reg(CFG_BLOCKS_IN_USE, 5'd16);
    endtask

    task automatic test_fit_policies();
        send_item(mk(CMD_LOAD, 4'd0, 16'd100));
        send_item(mk(CMD_LOAD, 4'd15, 16'hFFFF));
        send_item(mk(CMD_LOAD, 4'd3, 16'd40));
        send_item(mk(CMD_LOAD, 4'd7, 16'd40));
        send_item(mk(CMD_LOAD, 4'd9, 16'd200));
        send_item(mk(CMD_ALLOC, 4'd5, 16'd40));
        settle();
        // tie between two equal blocks goes to the lower index
        write_reg(CFG_FIT_MODE, {3'b000, MODE_BEST});
        send_item(mk(CMD_ALLOC, 4'd0, 16'd40));
        settle();
        write_reg(CFG_FIT_MODE, {3'b000, MODE_WORST});
        send_item(mk(CMD_ALLOC, 4'd0, 16'd1));
        send_item(mk(CMD_ALLOC, 4'd0, 16'hFFFF));
        send_item(mk(CMD_LOAD, 4'd15, 16'hFFFF));
        send_item(mk(CMD_ALLOC, 4'd0, 16'hFFFF));
        settle();
        write_reg(CFG_FIT_MODE, {3'b000, MODE_SPARE});
        send_item(mk(CMD_ALLOC, 4'd0, 16'd50));
        settle();
    endtask

    task automatic test_search_length();
        write_reg(CFG_BLOCKS_IN_USE, 5'd0);
        send_item(mk(CMD_ALLOC, 4'd0, 16'd0));
        settle();
        // upper mode bits are don't-care, overlong search clamps to the table size
        write_reg(CFG_FIT_MODE, {3'b111, MODE_BEST});
        write_reg(CFG_BLOCKS_IN_USE, 5'd31);
        send_item(mk(CMD_ALLOC, 4'd0, 16'd150));
        settle();
        write_reg(CFG_BLOCKS_IN_USE, 5'd1);
        send_item(mk(CMD_ALLOC, 4'd0, 16'd5));
        send_item(mk(CMD_ALLOC, 4'd0, 16'd6));
        send_item(mk(CMD_LOAD, 4'd0, 16'd0));
        settle();
    endtask

    function automatic logic [15:0] alloc_amount();
        int          n;
        logic [15:0] v;
        n = (blocks_q > NUM_BLOCKS) ? NUM_BLOCKS : int'(blocks_q);
        v = (n == 0) ? 16'($urandom) : free_tbl[$urandom_range(0, n - 1)];
        case ($urandom_range(0, 9))
            0, 1, 2: return v;
            3, 4, 5: return 16'($urandom_range(0, v));
            6:       return 16'd0;
            7:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] load_amount();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic test_random_traffic();
        logic [4:0]  blocks;
        int unsigned len;
        int unsigned fill;
        for (int p = 0; p < 16; p++) begin
            case ((p * 3) % 8)
                0, 6:    blocks = 5'd16;
                1:       blocks = 5'd1;
                2:       blocks = 5'($urandom_range(2, 15));
                3:       blocks = 5'd0;
                4:       blocks = 5'd31;
                5:       blocks = 5'($urandom_range(17, 30));
                default: blocks = 5'($urandom_range(1, 16));
            endcase
            write_reg(CFG_FIT_MODE, {3'($urandom), 2'(p % 4)});
            write_reg(CFG_BLOCKS_IN_USE, blocks);
            idle_on = (p % 3 != 2);
            // count 0 refuses every allocate, keep those phases short
            len  = (blocks == 5'd0) ? 20 : $urandom_range(64, 82);
            fill = $urandom_range(1, 16);
            for (int k = 0; k < len; k++) begin
                if (k < fill)
                    send_item(mk(CMD_LOAD, 4'($urandom), load_amount()));
                else if ($urandom_range(0, 3) == 0)
                    send_item(mk(CMD_LOAD, 4'($urandom), load_amount()));
                else
                    send_item(mk(CMD_ALLOC, 4'($urandom), alloc_amount()));
            end
            settle();
        end
    endtask

    initial begin
        foreach (free_tbl[i])
            free_tbl[i] = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_cleared_table();
        test_fit_policies();
        test_search_length();
        test_random_traffic();
        settle();
        $display("covered %0d loads and %0d allocations, %0d of them granted, %0d results checked",
                 n_loads, n_allocs, n_granted, n_checked);
        $display("fit modes 0-3 with search lengths 0, 1, partial, 16 and beyond the table");
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
